FILE: rtl/fully_assoc_tlb_lru_defines.svh
// Assertion helpers for the checker file.
// Both expect clk in the scope of the use; FATL_ASSERT also expects rst_n.
`ifndef FULLY_ASSOC_TLB_LRU_DEFINES_SVH
`define FULLY_ASSOC_TLB_LRU_DEFINES_SVH

// Clocked check, off while reset is asserted.
`define FATL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs through reset.
`define FATL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/fatl_pkg.sv
package fatl_pkg;

  localparam int TLB_ENTRIES = 16;
  localparam int IDX_W       = $clog2(TLB_ENTRIES);

  localparam int VPN_W    = 36;
  localparam int THREAD_W = 2;
  localparam int PFN_W    = 32;
  localparam int COUNT_W  = 32;

  localparam logic [IDX_W-1:0] LRU_RANK = IDX_W'(TLB_ENTRIES - 1);

  localparam logic MODE_LOOKUP  = 1'b0;
  localparam logic MODE_INSTALL = 1'b1;

  typedef struct packed {
    logic                mode;
    logic [VPN_W-1:0]    vpn;
    logic [THREAD_W-1:0] thread_id;
    logic [PFN_W-1:0]    install_pfn;
  } fatl_in_t;

  typedef struct packed {
    logic               hit;
    logic [PFN_W-1:0]   hit_pfn;
    logic [COUNT_W-1:0] access_count;
    logic [COUNT_W-1:0] miss_count;
  } fatl_out_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } fatl_state_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } fatl_cmd_t;

endpackage

FILE: rtl/fatl_ctrl.sv
module fatl_ctrl
  import fatl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output fatl_cmd_t cmd
);

  fatl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_EXEC;
      ST_EXEC: if (slot_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_EXEC: cmd.execute = slot_free;
      default: ;
    endcase
  end

  // Load on execute, drop once the word is taken.
  assign out_valid_nxt = cmd.execute ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  assign out_valid     = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: rtl/fatl_datapath.sv
module fatl_datapath
  import fatl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  fatl_cmd_t cmd,
  input  fatl_in_t  in_data,
  output fatl_out_t out_data
);

  fatl_in_t            req_r;
  logic                valid_r  [TLB_ENTRIES];
  logic [VPN_W-1:0]    page_r   [TLB_ENTRIES];
  logic [THREAD_W-1:0] thread_r [TLB_ENTRIES];
  logic [PFN_W-1:0]    frame_r  [TLB_ENTRIES];
  logic [IDX_W-1:0]    rank_r   [TLB_ENTRIES];
  logic [IDX_W-1:0]    rank_nxt [TLB_ENTRIES];
  logic [COUNT_W-1:0]  acc_r, acc_nxt;
  logic [COUNT_W-1:0]  miss_r, miss_nxt;
  fatl_out_t           out_r, out_nxt;

  logic             is_lookup;
  logic             hit_any, free_any;
  logic [IDX_W-1:0] hit_idx, free_idx, lru_idx, sel_idx, sel_rank;
  logic             touch_en;

  assign is_lookup = (req_r.mode == MODE_LOOKUP);

  // Lowest-numbered hit, free slot and LRU slot: scan high to low.
  always_comb begin
    hit_any  = 1'b0;
    free_any = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    lru_idx  = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (valid_r[i] && thread_r[i] == req_r.thread_id && page_r[i] == req_r.vpn) begin
        hit_any = 1'b1;
        hit_idx = IDX_W'(i);
      end
      if (!valid_r[i]) begin
        free_any = 1'b1;
        free_idx = IDX_W'(i);
      end
      if (rank_r[i] == LRU_RANK) lru_idx = IDX_W'(i);
    end
  end

  assign sel_idx  = is_lookup ? hit_idx : (free_any ? free_idx : lru_idx);
  assign touch_en = is_lookup ? hit_any : 1'b1;
  assign sel_rank = rank_r[sel_idx];

  // Promote the selected slot; slots younger than it age by one.
  always_comb begin
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      rank_nxt[i] = rank_r[i];
      if (touch_en) begin
        if (IDX_W'(i) == sel_idx) rank_nxt[i] = '0;
        else if (rank_r[i] < sel_rank) rank_nxt[i] = rank_r[i] + IDX_W'(1);
      end
    end
  end

  assign acc_nxt  = (&acc_r) ? acc_r : acc_r + COUNT_W'(1);
  assign miss_nxt = (is_lookup && !hit_any && !(&miss_r)) ? miss_r + COUNT_W'(1) : miss_r;

  always_comb begin
    out_nxt.hit          = is_lookup && hit_any;
    out_nxt.hit_pfn      = (is_lookup && hit_any) ? frame_r[hit_idx] : '0;
    out_nxt.access_count = acc_nxt;
    out_nxt.miss_count   = miss_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      miss_r <= '0;
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        valid_r[i] <= 1'b0;
        rank_r[i]  <= IDX_W'(i);
      end
    end else if (cmd.execute) begin
      acc_r  <= acc_nxt;
      miss_r <= miss_nxt;
      for (int i = 0; i < TLB_ENTRIES; i++) rank_r[i] <= rank_nxt[i];
      if (!is_lookup) valid_r[sel_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) req_r <= in_data;
    if (cmd.execute) begin
      out_r <= out_nxt;
      if (!is_lookup) begin
        page_r[sel_idx]   <= req_r.vpn;
        thread_r[sel_idx] <= req_r.thread_id;
        frame_r[sel_idx]  <= req_r.install_pfn;
      end
    end
  end

  assign out_data = out_r;

endmodule

FILE: rtl/fully_assoc_tlb_lru.sv
// Sixteen-entry fully associative TLB tagged by thread and virtual page, with exact LRU
// replacement. A lookup word (mode 0) compares all valid entries in parallel and returns
// hit and frame of the lowest-numbered match, promoting it to most recent; a miss bumps
// the miss count. An install word (mode 1) writes the lowest free entry, or the LRU one
// when all are valid, with no duplicate check. Every word bumps the access count; both
// counts stick at all ones. A word's request is registered first; the parallel tag
// compare, rank update and result load follow. The result sits in an output register,
// so the next word is taken while it waits; a stalled result holds the following word
// in its compare cycle until the output register frees up.
module fully_assoc_tlb_lru
  import fatl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  fatl_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output fatl_out_t out_data
);

  fatl_cmd_t cmd;

  fatl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  fatl_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

FILE: rtl/fatl_checker.sv
`include "fully_assoc_tlb_lru_defines.svh"

module fatl_checker
  import fatl_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input fatl_out_t out_data
);

  logic miss_ok;

  assign miss_ok = (out_data.miss_count <= out_data.access_count);

  `FATL_ASSERT(a_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "result moved")
  `FATL_ASSERT(a_one_in_flight, in_valid && in_ready |=> !in_ready, "word taken in compare cycle")
  `FATL_ASSERT(a_miss_le_acc, out_valid |-> miss_ok, "miss count above access count")
  `FATL_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid, "result valid right after reset")

endmodule

bind fully_assoc_tlb_lru fatl_checker u_fatl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
